// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPLIES_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/acws_pkg.sv =====
// types and character constants for the comment and whitespace stripper
`default_nettype none

package acws_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [1:0] {
        MODE_CODE  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_BLOCK = 2'd2
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t mode;
        logic       slash_pending;
        logic       star_before;
        logic       emitted_any;
        logic       last_was_newline;
    } scan_state_t;

    localparam scan_state_t SCAN_STATE_RESET = '{
        mode:             MODE_CODE,
        slash_pending:    1'b0,
        star_before:      1'b0,
        emitted_any:      1'b0,
        last_was_newline: 1'b0
    };

endpackage

`default_nettype wire

// ===== src/asm_comment_whitespace_stripper_top.sv =====
// Assembly source stripper: drops blanks and C-style comments from a byte stream.
// Input channel s_axis: one raw source byte per transfer in tdata, tlast marks
// the last byte of a file; the byte is processed and the scanner then returns
// to its reset state.
// Output channel m_axis: zero or one byte per input byte, either a kept code
// byte or a line feed; repeated and leading line feeds are suppressed.
// Throughput: one byte per cycle while no result waits on a stalled output. An
// input byte is held in an input register, the scanner update is a small block
// of logic, and the result goes to an output register that drives m_axis.
// The scan state advances when the byte leaves the input register, so bytes
// follow each other with no bubbles.
// Stall: while m_axis_tready is low with a result waiting, a byte that yields
// nothing still passes; a byte that yields a result waits in the input register
// and s_axis_tready drops until the output register frees.
// Reset: rst_n clears both registers' valid flags and the scan state (code
// mode, nothing emitted); no clearing pass is needed.
`default_nettype none

module asm_comment_whitespace_stripper_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // end_of_stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [7:0] out_byte
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    acws_pkg::scan_state_t state_reg;
    acws_pkg::scan_state_t state_next;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;

    logic       step_emit;
    logic [7:0] step_byte;
    logic       out_free;
    logic       step_fire;
    logic       in_fire;

    acws_step u_step
    (
        .cur           (state_reg),
        .in_byte       (in_byte_reg),
        .end_of_stream (in_last_reg),
        .nxt           (state_next),
        .emit          (step_emit),
        .emit_byte     (step_byte)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_fire     = in_valid_reg && (!step_emit || out_free);
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= acws_pkg::SCAN_STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step_fire)
            begin
                state_reg <= state_next;
            end

            if (step_fire && step_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step_fire && step_emit)
        begin
            out_byte_reg <= step_byte;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;

endmodule

`default_nettype wire

// ===== src/acws_step.sv =====
// per-byte scanner update: next scan state and the byte to emit, if any
`default_nettype none

module acws_step
(
    input  wire acws_pkg::scan_state_t cur,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  end_of_stream,
    output acws_pkg::scan_state_t      nxt,
    output logic                       emit,
    output logic [7:0]                 emit_byte
);

    logic nl_ok;
    logic emit_raw;
    logic emit_lf;
    acws_pkg::scan_state_t upd;

    assign nl_ok = cur.emitted_any && !cur.last_was_newline;

    always_comb
    begin
        upd      = cur;
        emit_raw = 1'b0;
        emit_lf  = 1'b0;
        case (cur.mode)
            acws_pkg::MODE_LINE:
            begin
                if (in_byte == acws_pkg::CH_LF)
                begin
                    upd.mode = acws_pkg::MODE_CODE;
                    emit_lf  = nl_ok;
                end
            end
            acws_pkg::MODE_BLOCK:
            begin
                if (cur.star_before && in_byte == acws_pkg::CH_SLASH)
                begin
                    upd.mode        = acws_pkg::MODE_CODE;
                    upd.star_before = 1'b0;
                    emit_lf         = nl_ok;
                end
                else
                begin
                    upd.star_before = (in_byte == acws_pkg::CH_STAR);
                end
            end
            default:
            begin
                upd.slash_pending = 1'b0;
                if (cur.slash_pending && in_byte == acws_pkg::CH_SLASH)
                begin
                    upd.mode = acws_pkg::MODE_LINE;
                end
                else if (cur.slash_pending && in_byte == acws_pkg::CH_STAR)
                begin
                    // opening star never counts toward the closing pair
                    upd.mode        = acws_pkg::MODE_BLOCK;
                    upd.star_before = 1'b0;
                end
                else
                begin
                    case (in_byte) inside
                        acws_pkg::CH_SPACE, acws_pkg::CH_TAB:
                        begin
                            emit_raw = 1'b0;
                        end
                        acws_pkg::CH_CR, acws_pkg::CH_LF:
                        begin
                            emit_lf = nl_ok;
                        end
                        acws_pkg::CH_SLASH:
                        begin
                            upd.slash_pending = 1'b1;
                        end
                        default:
                        begin
                            emit_raw = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        emit      = emit_raw || emit_lf;
        emit_byte = emit_lf ? acws_pkg::CH_LF : in_byte;
        if (emit)
        begin
            upd.emitted_any      = 1'b1;
            upd.last_was_newline = (emit_byte == acws_pkg::CH_LF);
        end

        nxt = end_of_stream ? acws_pkg::SCAN_STATE_RESET : upd;
    end

endmodule

`default_nettype wire

// ===== src/acws_checker.sv =====
// port-level checks for the stripper, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module acws_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    logic any_out_reg;
    logic last_lf_reg;

    // track what has left since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_out_reg <= 1'b0;
            last_lf_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            any_out_reg <= 1'b1;
            last_lf_reg <= (m_axis_tdata == acws_pkg::CH_LF);
        end
    end

    `ASSERT_IMPLIES_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
        s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast),
        "stalled input transfer changed")

    `ASSERT_IMPLIES_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled output transfer changed")

    `ASSERT_IMPLIES(a_no_blank, m_axis_tvalid,
        m_axis_tdata != acws_pkg::CH_SPACE && m_axis_tdata != acws_pkg::CH_TAB &&
        m_axis_tdata != acws_pkg::CH_SLASH && m_axis_tdata != acws_pkg::CH_CR,
        "blank, slash or carriage return reached the output")

    `ASSERT_IMPLIES(a_no_extra_lf, m_axis_tvalid && (last_lf_reg || !any_out_reg),
        m_axis_tdata != acws_pkg::CH_LF, "leading or repeated line feed on output")

endmodule

bind asm_comment_whitespace_stripper_top acws_checker u_acws_checker (.*);

`default_nettype wire

// ===== tb/sv/asm_comment_whitespace_stripper_top_tb.sv =====
// testbench for the comment and whitespace stripper: directed and random byte streams
`timescale 1ns / 1ps

module asm_comment_whitespace_stripper_top_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;    // end_of_stream
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte

    asm_comment_whitespace_stripper_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // predicted scanner state and the bytes it says will come out
    acws_pkg::scan_state_t scan_state = acws_pkg::SCAN_STATE_RESET;
    logic [7:0]  stripped_bytes[$];

    int  items_sent      = 0;
    int  files_ended     = 0;
    int  results_checked = 0;
    int  error_count     = 0;
    int  cycle_count     = 0;
    bit  src_idle        = 1'b1;
    bit  sink_idle       = 1'b1;
    int  hold_requests   = 0;
    int  hold_served     = 0;
    int  hold_left       = 0;
    int  stall_left      = 0;

    function automatic void emit_char(input logic [7:0] b);
        stripped_bytes.push_back(b);
        scan_state.emitted_any      = 1'b1;
        scan_state.last_was_newline = (b == acws_pkg::CH_LF);
    endfunction

    function automatic void emit_newline();
        if (scan_state.emitted_any && !scan_state.last_was_newline)
            emit_char(acws_pkg::CH_LF);
    endfunction

    function automatic void code_char(input logic [7:0] b);
        if (b == acws_pkg::CH_SPACE || b == acws_pkg::CH_TAB)
            return;
        if (b == acws_pkg::CH_CR || b == acws_pkg::CH_LF)
            emit_newline();
        else if (b == acws_pkg::CH_SLASH)
            scan_state.slash_pending = 1'b1;
        else
            emit_char(b);
    endfunction

    function automatic void strip_byte(input logic [7:0] b, input logic last);
        case (scan_state.mode)
            acws_pkg::MODE_LINE:
            begin
                if (b == acws_pkg::CH_LF)
                begin
                    scan_state.mode = acws_pkg::MODE_CODE;
                    emit_newline();
                end
            end
            acws_pkg::MODE_BLOCK:
            begin
                if (scan_state.star_before && b == acws_pkg::CH_SLASH)
                begin
                    scan_state.mode        = acws_pkg::MODE_CODE;
                    scan_state.star_before = 1'b0;
                    emit_newline();
                end
                else
                begin
                    scan_state.star_before = (b == acws_pkg::CH_STAR);
                end
            end
            default:
            begin
                if (scan_state.slash_pending)
                begin
                    scan_state.slash_pending = 1'b0;
                    if (b == acws_pkg::CH_SLASH)
                        scan_state.mode = acws_pkg::MODE_LINE;
                    else if (b == acws_pkg::CH_STAR)
                    begin
                        scan_state.mode        = acws_pkg::MODE_BLOCK;
                        scan_state.star_before = 1'b0;
                    end
                    else
                        code_char(b);
                end
                else
                begin
                    code_char(b);
                end
            end
        endcase
        if (last)
            scan_state = acws_pkg::SCAN_STATE_RESET;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic bit maybe_last();
        return ($urandom_range(0, 79) == 0);
    endfunction

    // a comment body byte, biased toward the bytes that can close a comment
    function automatic logic [7:0] comment_byte();
        case ($urandom_range(0, 3))
            0:       return acws_pkg::CH_STAR;
            1:       return acws_pkg::CH_SLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // offers one byte and waits for its transfer; valid stays high for the next call
    task automatic send_item(input logic [7:0] b, input logic last);
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        strip_byte(b, last);
        items_sent++;
        if (last)
            files_ended++;
    endtask

    task automatic send_text(input string s, input logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], last_on_end && (i == s.len() - 1));
    endtask

    task automatic send_token();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2:
                repeat ($urandom_range(1, 6)) send_item(printable(), maybe_last());
            3:
                repeat ($urandom_range(1, 4))
                    send_item($urandom_range(0, 1) ? acws_pkg::CH_SPACE : acws_pkg::CH_TAB,
                              maybe_last());
            4:
            begin
                case ($urandom_range(0, 2))
                    0: send_item(acws_pkg::CH_LF, maybe_last());
                    1: send_item(acws_pkg::CH_CR, maybe_last());
                    default:
                    begin
                        send_item(acws_pkg::CH_CR, maybe_last());
                        send_item(acws_pkg::CH_LF, maybe_last());
                    end
                endcase
            end
            5:
            begin
                send_item(acws_pkg::CH_SLASH, 1'b0);
                send_item(acws_pkg::CH_SLASH, maybe_last());
                repeat ($urandom_range(0, 8))
                begin
                    b = comment_byte();
                    send_item((b == acws_pkg::CH_LF) ? acws_pkg::CH_CR : b, maybe_last());
                end
                send_item(acws_pkg::CH_LF, maybe_last());
            end
            6:
            begin
                send_item(acws_pkg::CH_SLASH, 1'b0);
                send_item(acws_pkg::CH_STAR, maybe_last());
                repeat ($urandom_range(0, 8)) send_item(comment_byte(), maybe_last());
                send_item(acws_pkg::CH_STAR, 1'b0);
                send_item(acws_pkg::CH_SLASH, maybe_last());
            end
            7:
            begin
                send_item(acws_pkg::CH_SLASH, 1'b0);
                send_item(8'($urandom_range(0, 255)), maybe_last());
            end
            8:
                send_item(8'($urandom_range(0, 255)), maybe_last());
            default:
                send_item($urandom_range(0, 1) ? acws_pkg::CH_SLASH : printable(), 1'b1);
        endcase
    endtask

    task automatic test_directed();
        send_item(acws_pkg::CH_LF, 1'b0);       // nothing sent yet, so no line feed
        send_item(acws_pkg::CH_SPACE, 1'b0);
        send_item(acws_pkg::CH_TAB, 1'b0);
        send_item(8'h00, 1'b0);                 // nul passes like code
        send_item(8'hFF, 1'b0);
        send_item(acws_pkg::CH_CR, 1'b0);       // cr lf collapse to one lf
        send_item(acws_pkg::CH_LF, 1'b0);
        send_text("/a", 1'b0);                  // dropped slash, byte kept
        send_text("//x", 1'b0);
        send_item(acws_pkg::CH_CR, 1'b0);       // cr does not end a line comment
        send_item(acws_pkg::CH_LF, 1'b0);
        send_text("z/*/x*/", 1'b0);             // opening star cannot close the comment
        send_text("q/", 1'b1);                  // trailing slash at end of file
    endtask

    task automatic test_random_text(input int target);
        int start;
        start = items_sent;
        src_idle = 1'b1;
        sink_idle <= 1'b1;
        while (items_sent - start < target)
            send_token();
    endtask

    // receiver holds off while letters keep coming, so the input side must stall
    task automatic test_input_stall();
        src_idle = 1'b0;
        hold_requests <= hold_requests + 1;
        repeat (40) send_item(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
        src_idle = 1'b1;
    endtask

    task automatic test_full_rate(input int target);
        int start;
        start = items_sent;
        src_idle = 1'b0;
        sink_idle <= 1'b0;
        while (items_sent - start < target)
            send_token();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_output
        logic [7:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (stripped_bytes.size() == 0)
            begin
                $display("%0t: unexpected output transfer, expected none, actual 0x%02h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = stripped_bytes.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: out_byte mismatch, expected 0x%02h, actual 0x%02h",
                             $time, want, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes still expected", $time, stripped_bytes.size());
            $display("asm_comment_whitespace_stripper_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_text(850);
        test_input_stall();
        test_full_rate(100);
        s_axis_tvalid <= 1'b0;
        while (stripped_bytes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("sent %0d source bytes over %0d file ends, checked %0d stripped bytes",
                 items_sent, files_ended, results_checked);
        $display("covered comments, blanks, line ends, stray slashes, noise and output stalls");
        if (error_count == 0)
            $display("asm_comment_whitespace_stripper_top_tb: clean");
        else
            $display("asm_comment_whitespace_stripper_top_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/acws_pkg.sv
src/acws_step.sv
src/asm_comment_whitespace_stripper_top.sv
src/acws_checker.sv
tb/sv/asm_comment_whitespace_stripper_top_tb.sv
